@@ rtl/core/erast_pkg.sv @@
// Package for the ellipse rasterizer: widths, request codes and the structs
// passed between the top level, the sequencer and the shared multiply-add unit.
// No dependencies.
package erast_pkg;

	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 64;

	localparam int X_W   = $clog2(SCREEN_WIDTH);
	localparam int Y_W   = $clog2(SCREEN_HEIGHT);
	localparam int OFS_W = X_W + 1;
	localparam int MUL_W = 17;
	localparam int ACC_W = 32;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	typedef struct packed {
		logic           req_type;
		logic [X_W-1:0] corner_a_x;
		logic [Y_W-1:0] corner_a_y;
		logic [X_W-1:0] corner_b_x;
		logic [Y_W-1:0] corner_b_y;
	} req_t;

	typedef struct packed {
		logic           point_valid;
		logic           last_point;
		logic [X_W-1:0] x_right;
		logic [X_W-1:0] x_left;
		logic [Y_W-1:0] y_below;
		logic [Y_W-1:0] y_above;
	} res_t;

	typedef struct packed {
		logic [ACC_W-1:0] addend;
		logic [MUL_W-1:0] opa;
		logic [MUL_W-1:0] opb;
		logic             neg;
	} mac_req_t;

endpackage

@@ rtl/core/erast_mac.sv @@
// Shared signed multiply-add unit: sum = addend +/- opa * opb.
// Depends on erast_pkg.
module erast_mac (
	input  erast_pkg::mac_req_t               req,
	output logic signed [erast_pkg::ACC_W-1:0] sum
);

	localparam int MUL_W = erast_pkg::MUL_W;
	localparam int ACC_W = erast_pkg::ACC_W;

	logic signed [2*MUL_W-1:0] prod;
	logic signed [2*MUL_W-1:0] term;

	always_comb begin
		prod = $signed(req.opa) * $signed(req.opb);
		term = req.neg ? -prod : prod;
		sum  = $signed(req.addend) + $signed(term[ACC_W-1:0]);
	end

endmodule

@@ rtl/core/erast_core.sv @@
// Sequencer for the midpoint ellipse: holds the ellipse state and steps the
// shared multiply-add unit through setup, point advance and region change.
// Depends on erast_pkg and erast_mac.
module erast_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_fire,
	input  erast_pkg::req_t   req,
	output logic              idle,
	output logic              done,
	output erast_pkg::res_t   res
);

	localparam int X_W   = erast_pkg::X_W;
	localparam int Y_W   = erast_pkg::Y_W;
	localparam int OFS_W = erast_pkg::OFS_W;
	localparam int MUL_W = erast_pkg::MUL_W;
	localparam int ACC_W = erast_pkg::ACC_W;
	localparam int A_W   = X_W - 1;
	localparam int B_W   = Y_W - 1;

	localparam erast_pkg::res_t RES_END = '{point_valid: 1'b0, last_point: 1'b1,
		x_right: '0, x_left: '0, y_below: '0, y_above: '0};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A2,
		ST_B2,
		ST_P0A,
		ST_P0B,
		ST_ADV1,
		ST_ADV2,
		ST_SET1,
		ST_SET2,
		ST_E1,
		ST_E2,
		ST_E3,
		ST_E4,
		ST_E5,
		ST_FIN
	} state_t;

	state_t                    state_q;
	logic [X_W-1:0]            cx_q;
	logic [Y_W-1:0]            cy_q;
	logic [A_W-1:0]            a_q;
	logic [B_W-1:0]            b_q;
	logic [2*A_W-1:0]          a2_q;
	logic [2*B_W-1:0]          b2_q;
	logic signed [OFS_W-1:0]   x_q;
	logic signed [OFS_W-1:0]   y_q;
	logic signed [ACC_W-1:0]   p_q;
	logic signed [ACC_W-1:0]   s_q;
	logic                      r2_q;
	logic                      busy_q;
	erast_pkg::res_t           res_q;

	// box setup
	logic [X_W-1:0] x_lo, x_hi, x_span;
	logic [Y_W-1:0] y_lo, y_hi, y_span;
	logic [X_W:0]   x_sum;
	logic [Y_W:0]   y_sum;
	logic           reject;

	// current point
	logic [X_W-1:0] x_right, x_left;
	logic [Y_W-1:0] y_below, y_above;

	// operands
	logic signed [MUL_W-1:0] xs, ys, x_p1, x_2p3, x_2p2, y_m1, y_2n, y_1m2, y_3m2;
	logic signed [MUL_W-1:0] a_op, b_op, a2_op, b2_op, s_op, one_op;

	erast_pkg::mac_req_t     mac_req;
	logic signed [ACC_W-1:0] mac_sum;

	erast_mac u_mac (
		.req (mac_req),
		.sum (mac_sum)
	);

	always_comb begin
		x_lo   = (req.corner_a_x < req.corner_b_x) ? req.corner_a_x : req.corner_b_x;
		x_hi   = (req.corner_a_x < req.corner_b_x) ? req.corner_b_x : req.corner_a_x;
		y_lo   = (req.corner_a_y < req.corner_b_y) ? req.corner_a_y : req.corner_b_y;
		y_hi   = (req.corner_a_y < req.corner_b_y) ? req.corner_b_y : req.corner_a_y;
		x_sum  = {1'b0, x_lo} + {1'b0, x_hi};
		y_sum  = {1'b0, y_lo} + {1'b0, y_hi};
		x_span = x_hi - x_lo;
		y_span = y_hi - y_lo;
		reject = (req.corner_a_x == req.corner_b_x) || (req.corner_a_y == req.corner_b_y);
	end

	// coordinates wrap with the screen, which is a power of two
	assign x_right = cx_q + x_q[X_W-1:0];
	assign x_left  = cx_q - x_q[X_W-1:0];
	assign y_below = cy_q + y_q[Y_W-1:0];
	assign y_above = cy_q - y_q[Y_W-1:0];

	always_comb begin
		xs     = MUL_W'(x_q);
		ys     = MUL_W'(y_q);
		one_op = MUL_W'(1);
		x_p1   = xs + one_op;
		x_2p3  = (xs <<< 1) + MUL_W'(3);
		x_2p2  = (xs <<< 1) + MUL_W'(2);
		y_m1   = ys - one_op;
		y_2n   = -(ys <<< 1);
		y_1m2  = one_op - (ys <<< 1);
		y_3m2  = MUL_W'(3) - (ys <<< 1);
		a_op   = MUL_W'(a_q);
		b_op   = MUL_W'(b_q);
		a2_op  = MUL_W'(a2_q);
		b2_op  = MUL_W'(b2_q);
		s_op   = s_q[MUL_W-1:0];
	end

	always_comb begin
		mac_req = '{addend: p_q, opa: '0, opb: '0, neg: 1'b0};
		case (state_q)
			ST_A2: begin
				mac_req = '{addend: '0, opa: a_op, opb: a_op, neg: 1'b0};
			end
			ST_B2: begin
				mac_req = '{addend: '0, opa: b_op, opb: b_op, neg: 1'b0};
			end
			ST_P0A: begin
				mac_req = '{addend: ACC_W'(a2_q[2*A_W-1:2]), opa: a2_op, opb: b_op,
					neg: 1'b1};
			end
			ST_P0B: begin
				mac_req = '{addend: p_q, opa: b2_op, opb: one_op, neg: 1'b0};
			end
			ST_ADV1: begin
				if (!r2_q) begin
					mac_req = '{addend: p_q, opa: b2_op, opb: x_2p3, neg: 1'b0};
				end else if (p_q > 0) begin
					mac_req = '{addend: p_q, opa: a2_op, opb: y_3m2, neg: 1'b0};
				end else begin
					mac_req = '{addend: p_q, opa: b2_op, opb: x_2p2, neg: 1'b0};
				end
			end
			ST_ADV2: begin
				mac_req = '{addend: p_q, opa: a2_op, opb: (r2_q ? y_1m2 : y_2n), neg: 1'b0};
			end
			ST_SET1: begin
				mac_req = '{addend: '0, opa: b2_op, opb: xs, neg: 1'b0};
			end
			ST_SET2: begin
				mac_req = '{addend: s_q, opa: a2_op, opb: ys, neg: 1'b1};
			end
			ST_E1: begin
				mac_req = '{addend: '0, opa: xs, opb: x_p1, neg: 1'b0};
			end
			ST_E2: begin
				mac_req = '{addend: '0, opa: b2_op, opb: s_op, neg: 1'b0};
			end
			ST_E3: begin
				mac_req = '{addend: '0, opa: y_m1, opb: y_m1, neg: 1'b0};
			end
			ST_E4: begin
				mac_req = '{addend: p_q, opa: a2_op, opb: s_op, neg: 1'b0};
			end
			ST_E5: begin
				mac_req = '{addend: p_q, opa: a2_op, opb: b2_op, neg: 1'b1};
			end
			default: begin
				mac_req = '{addend: p_q, opa: '0, opb: '0, neg: 1'b0};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cx_q    <= '0;
			cy_q    <= '0;
			a_q     <= '0;
			b_q     <= '0;
			a2_q    <= '0;
			b2_q    <= '0;
			x_q     <= '0;
			y_q     <= '0;
			p_q     <= '0;
			s_q     <= '0;
			r2_q    <= 1'b0;
			busy_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (req.req_type == erast_pkg::REQ_START) begin
							if (reject) begin
								busy_q  <= 1'b0;
								res_q   <= RES_END;
								state_q <= ST_FIN;
							end else begin
								res_q   <= '0;
								cx_q    <= x_sum[X_W:1];
								cy_q    <= y_sum[Y_W:1];
								a_q     <= x_span[X_W-1:1];
								b_q     <= y_span[Y_W-1:1];
								x_q     <= '0;
								y_q     <= OFS_W'(y_span[Y_W-1:1]);
								r2_q    <= 1'b0;
								busy_q  <= 1'b1;
								state_q <= ST_A2;
							end
						end else if (!busy_q) begin
							res_q   <= RES_END;
							state_q <= ST_FIN;
						end else begin
							res_q <= '{point_valid: 1'b1, last_point: 1'b0,
								x_right: x_right, x_left: x_left,
								y_below: y_below, y_above: y_above};
							state_q <= ST_ADV1;
						end
					end
				end
				ST_A2: begin
					a2_q    <= mac_sum[2*A_W-1:0];
					state_q <= ST_B2;
				end
				ST_B2: begin
					b2_q    <= mac_sum[2*B_W-1:0];
					state_q <= ST_P0A;
				end
				ST_P0A: begin
					p_q     <= mac_sum;
					state_q <= ST_P0B;
				end
				ST_P0B: begin
					p_q     <= mac_sum;
					state_q <= ST_SET1;
				end
				ST_ADV1: begin
					p_q <= mac_sum;
					if (!r2_q) begin
						x_q <= x_q + OFS_W'(1);
						if (p_q < 0) begin
							state_q <= ST_SET1;
						end else begin
							y_q     <= y_q - OFS_W'(1);
							state_q <= ST_ADV2;
						end
					end else begin
						y_q <= y_q - OFS_W'(1);
						if (p_q > 0) begin
							state_q <= ST_SET1;
						end else begin
							x_q     <= x_q + OFS_W'(1);
							state_q <= ST_ADV2;
						end
					end
				end
				ST_ADV2: begin
					p_q     <= mac_sum;
					state_q <= ST_SET1;
				end
				ST_SET1: begin
					if (r2_q) begin
						if (y_q[OFS_W-1]) begin
							busy_q <= 1'b0;
						end
						state_q <= ST_FIN;
					end else begin
						s_q     <= mac_sum;
						state_q <= ST_SET2;
					end
				end
				ST_SET2: begin
					s_q <= mac_sum;
					if (mac_sum[ACC_W-1]) begin
						state_q <= ST_FIN;
					end else begin
						r2_q    <= 1'b1;
						state_q <= ST_E1;
					end
				end
				ST_E1: begin
					s_q     <= mac_sum;
					state_q <= ST_E2;
				end
				ST_E2: begin
					p_q     <= mac_sum;
					state_q <= ST_E3;
				end
				ST_E3: begin
					s_q     <= mac_sum;
					state_q <= ST_E4;
				end
				ST_E4: begin
					p_q     <= mac_sum;
					state_q <= ST_E5;
				end
				ST_E5: begin
					p_q <= mac_sum;
					if (y_q[OFS_W-1]) begin
						busy_q <= 1'b0;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign idle = (state_q == ST_IDLE);
	assign done = (state_q == ST_FIN);

	always_comb begin
		res = res_q;
		if (res_q.point_valid) begin
			res.last_point = !busy_q;
		end
	end

	// region 2 is left only by a new start
	a_r2_exit: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(r2_q) |-> $past(state_q) == ST_IDLE)
		else $error("region flag cleared outside a start request");

	// a pending point never has a negative y offset
	a_pending_y: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && busy_q) |-> !y_q[OFS_W-1])
		else $error("pending point below the axis");

	// x offset only grows while a request is being worked
	a_x_grows: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) != ST_IDLE) |-> (x_q >= $past(x_q)))
		else $error("x offset decreased during a step");

endmodule

@@ rtl/core/ellipse_rasterizer_unit.sv @@
// Top level of the midpoint ellipse rasterizer: request/response handshakes
// and the response register. Depends on erast_pkg and erast_core.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_type, corner_a_x/y, corner_b_x/y
//  rsp     | out       | rsp_valid/rsp_ready  | point_valid, last_point, x_/y_ coords
//
// One request at a time; one multiply-add per cycle sets the latency.
// Start: squares the semi-axes, sets the first decision value, tests for region 2 and,
// if the ellipse opens there, runs the region-change updates. Step: advances the point;
// in region 1 it repeats that test and updates. Rejected box or idle step: straight to finish.
// req_ready is low while a request is worked or a response waits; arst_n idles all.
module ellipse_rasterizer_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic                      req_type,
	input  logic [erast_pkg::X_W-1:0] corner_a_x,
	input  logic [erast_pkg::Y_W-1:0] corner_a_y,
	input  logic [erast_pkg::X_W-1:0] corner_b_x,
	input  logic [erast_pkg::Y_W-1:0] corner_b_y,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output logic                      point_valid,
	output logic                      last_point,
	output logic [erast_pkg::X_W-1:0] x_right,
	output logic [erast_pkg::X_W-1:0] x_left,
	output logic [erast_pkg::Y_W-1:0] y_below,
	output logic [erast_pkg::Y_W-1:0] y_above
);

	erast_pkg::req_t req;
	erast_pkg::res_t core_res;
	erast_pkg::res_t rsp_q;
	logic            core_idle;
	logic            core_done;
	logic            req_fire;
	logic            rsp_valid_q;

	assign req = '{req_type: req_type, corner_a_x: corner_a_x, corner_a_y: corner_a_y,
		corner_b_x: corner_b_x, corner_b_y: corner_b_y};

	assign req_ready = core_idle && !rsp_valid_q;
	assign req_fire  = req_valid && req_ready;

	erast_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_fire (req_fire),
		.req      (req),
		.idle     (core_idle),
		.done     (core_done),
		.res      (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (core_done) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= core_res;
		end else if (rsp_valid_q && rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign point_valid = rsp_q.point_valid;
	assign last_point  = rsp_q.last_point;
	assign x_right     = rsp_q.x_right;
	assign x_left      = rsp_q.x_left;
	assign y_below     = rsp_q.y_below;
	assign y_above     = rsp_q.y_above;

	// a finished request never lands on a response still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		core_done |-> !rsp_valid_q)
		else $error("response overwritten before it was taken");

endmodule
